// ----- sv/grmv_pkg.sv -----
// Package for the grouped running mean / variance block.
// Holds field widths, sizing constants and shared types; no dependencies.
package grmv_pkg;

  localparam int NUM_GROUPS  = 256;
  localparam int COUNT_WIDTH = 16;

  localparam int GRP_W     = 8;
  localparam int SMP_W     = 16;
  localparam int CNT_OUT_W = 16;
  localparam int MEAN_W    = 32;
  localparam int M2_W      = 48;
  localparam int DMAG_W    = 32;            // |delta| and |err| magnitudes
  localparam int PROD_W    = 2 * DMAG_W;
  localparam int FRAC_SH   = MEAN_W - SMP_W; // Q8.8 -> Q8.24 shift
  localparam int IDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  // Divider retires two quotient bits per cycle.
  localparam int DIV_STEPS = DMAG_W / 2;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef logic [GRP_W-1:0]        grp_t;
  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [COUNT_WIDTH-1:0]  cnt_t;
  typedef logic [CNT_OUT_W-1:0]    cnt_out_t;
  typedef logic [MEAN_W-1:0]       mean_t;
  typedef logic [M2_W-1:0]         m2_t;
  typedef logic [DMAG_W-1:0]       dmag_t;
  typedef logic [IDX_W-1:0]        idx_t;

  localparam cnt_t CNT_MAX = '1;
  localparam m2_t  M2_MAX  = '1;

  typedef struct packed {
    cnt_t  cnt;
    mean_t mean;
    m2_t   m2;
  } store_entry_t;

  typedef struct packed {
    logic         we;
    idx_t         waddr;
    store_entry_t wdata;
    logic         re;
    idx_t         raddr;
  } mem_req_t;

  typedef struct packed {
    logic  start;
    dmag_t dividend;
    cnt_t  divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    dmag_t quotient;
  } div_rsp_t;

  function automatic idx_t to_idx(grp_t g);
    return idx_t'(g);
  endfunction

  function automatic logic grp_in_range(grp_t g);
    return 32'(g) < 32'(NUM_GROUPS);
  endfunction

endpackage

// ----- sv/grmv_ifs.sv -----
// Handshake channel interfaces for the input items and the result items.
// Depends on grmv_pkg for field types.
interface grmv_in_if import grmv_pkg::*; ();
  logic    valid;
  logic    ready;
  grp_t    group;
  sample_t sample;
  logic    restart;

  modport source (output valid, output group, output sample, output restart, input ready);
  modport sink   (input valid, input group, input sample, input restart, output ready);
endinterface

interface grmv_out_if import grmv_pkg::*; ();
  logic     valid;
  logic     ready;
  grp_t     group_out;
  cnt_out_t count;
  mean_t    mean;
  m2_t      sq_dev_sum;
  logic     saturated;

  modport source (output valid, output group_out, output count, output mean,
                  output sq_dev_sum, output saturated, input ready);
  modport sink   (input valid, input group_out, input count, input mean,
                  input sq_dev_sum, input saturated, output ready);
endinterface

// ----- sv/grouped_running_mean_variance.sv -----
// Top level: Welford running mean / M2 per group, state in grmv_store,
// division through grmv_div. Depends on grmv_pkg and grmv_ifs.
//
//  channel | dir | handshake      | payload
//  in_i    | in  | valid / ready  | group, sample (Q8.8), restart
//  out_o   | out | valid / ready  | group_out, count, mean (Q8.24), sq_dev_sum, saturated
//
// One item at a time: a normal update passes through read, setup, the radix-4
// divider (16 steps, then done), then mean, error, multiply, accumulate and
// output, and returns to the accept state.
// A group out of range or at count limit skips the arithmetic: read goes straight to output.
// After reset a clearing pass writes zero to all NUM_GROUPS entries before
// the first item is accepted.
// The output register holds a result while out_o stalls; the next item is
// taken meanwhile and waits in the output step until the register frees.
module grouped_running_mean_variance import grmv_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  grmv_in_if.sink    in_i,
  grmv_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_SETUP, S_DIV, S_MEAN, S_ERR, S_MUL, S_ACC, S_OUT
  } state_e;

  localparam int DELTA_W  = MEAN_W + 1;
  localparam int M2_SUM_W = M2_W + 1;

  state_e state_q;
  idx_t   clr_idx_q;

  // Captured item.
  grp_t    grp_q;
  sample_t smp_q;
  logic    rst_grp_q;
  logic    in_range_q;

  // Working values of the current update.
  cnt_t                n_q;
  mean_t               mean_q;
  m2_t                 m2_q;
  logic                delta_neg_q;
  dmag_t               dmag_q;
  mean_t               nm_q;
  dmag_t               emag_q;
  logic [PROD_W-1:0]   prod_q;

  // Pending result, then output register.
  cnt_t  res_cnt_q;
  mean_t res_mean_q;
  m2_t   res_m2_q;
  logic  res_sat_q;

  logic     out_vld_q;
  grp_t     out_grp_q;
  cnt_out_t out_cnt_q;
  mean_t    out_mean_q;
  m2_t      out_m2_q;
  logic     out_sat_q;

  mem_req_t     mem_req;
  store_entry_t rdata;
  div_req_t     div_req;
  div_rsp_t     div_rsp;

  logic in_acc, out_free;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  // Sample widened to Q8.24.
  logic [MEAN_W-1:0] x_w;
  assign x_w = {smp_q, {FRAC_SH{1'b0}}};

  // Restart treats the stored entry as empty.
  cnt_t  eff_cnt;
  mean_t eff_mean;
  m2_t   eff_m2;
  assign eff_cnt  = rst_grp_q ? '0 : rdata.cnt;
  assign eff_mean = rst_grp_q ? '0 : rdata.mean;
  assign eff_m2   = rst_grp_q ? '0 : rdata.m2;

  // delta = x - mean, magnitude below 2^32.
  logic [DELTA_W-1:0] delta_w, delta_neg_w;
  dmag_t              dmag_w;
  assign delta_w     = {x_w[MEAN_W-1], x_w} - {mean_q[MEAN_W-1], mean_q};
  assign delta_neg_w = -delta_w;
  assign dmag_w      = delta_w[DELTA_W-1] ? delta_neg_w[DMAG_W-1:0] : delta_w[DMAG_W-1:0];

  // new mean = mean + trunc(delta / n); always fits Q8.24.
  logic [DELTA_W-1:0] q_w;
  logic [DELTA_W:0]   nm_w;
  assign q_w  = delta_neg_q ? -{1'b0, div_rsp.quotient} : {1'b0, div_rsp.quotient};
  assign nm_w = {{2{mean_q[MEAN_W-1]}}, mean_q} + {q_w[DELTA_W-1], q_w};

  // err = x - new mean, same sign as delta.
  logic [DELTA_W-1:0] err_w, err_neg_w;
  dmag_t              emag_w;
  assign err_w     = {x_w[MEAN_W-1], x_w} - {nm_q[MEAN_W-1], nm_q};
  assign err_neg_w = -err_w;
  assign emag_w    = err_w[DELTA_W-1] ? err_neg_w[DMAG_W-1:0] : err_w[DMAG_W-1:0];

  // M2 accumulate with saturation; increment keeps 16 fraction bits.
  logic [M2_SUM_W-1:0] m2_sum_w;
  m2_t                 m2_new_w;
  assign m2_sum_w = {1'b0, m2_q} + M2_SUM_W'(prod_q[PROD_W-1:DMAG_W]);
  assign m2_new_w = (m2_sum_w >= {1'b0, M2_MAX}) ? M2_MAX : m2_sum_w[M2_W-1:0];

  always_comb begin
    mem_req.re         = in_acc && grp_in_range(in_i.group);
    mem_req.raddr      = to_idx(in_i.group);
    mem_req.we         = (state_q == S_CLEAR) || (state_q == S_ACC);
    mem_req.waddr      = (state_q == S_CLEAR) ? clr_idx_q : to_idx(grp_q);
    mem_req.wdata.cnt  = (state_q == S_CLEAR) ? '0 : n_q;
    mem_req.wdata.mean = (state_q == S_CLEAR) ? '0 : nm_q;
    mem_req.wdata.m2   = (state_q == S_CLEAR) ? '0 : m2_new_w;
  end

  assign div_req.start    = (state_q == S_SETUP);
  assign div_req.dividend = dmag_w;
  assign div_req.divisor  = n_q;

  grmv_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  grmv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Control and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      out_grp_q  <= '0;
      out_cnt_q  <= '0;
      out_mean_q <= '0;
      out_m2_q   <= '0;
      out_sat_q  <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (out_vld_q && out_o.ready && state_q != S_OUT) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == idx_t'(NUM_GROUPS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          if (!in_range_q || eff_cnt == CNT_MAX) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_SETUP;
          end
        end
        S_SETUP: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) begin
            state_q <= S_MEAN;
          end
        end
        S_MEAN: state_q <= S_ERR;
        S_ERR:  state_q <= S_MUL;
        S_MUL:  state_q <= S_ACC;
        S_ACC:  state_q <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            out_vld_q  <= 1'b1;
            out_grp_q  <= grp_q;
            out_cnt_q  <= CNT_OUT_W'(res_cnt_q);
            out_mean_q <= res_mean_q;
            out_m2_q   <= res_m2_q;
            out_sat_q  <= res_sat_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      grp_q      <= in_i.group;
      smp_q      <= in_i.sample;
      rst_grp_q  <= in_i.restart;
      in_range_q <= grp_in_range(in_i.group);
    end
    case (state_q)
      S_READ: begin
        mean_q <= eff_mean;
        m2_q   <= eff_m2;
        n_q    <= eff_cnt + cnt_t'(1);
        if (!in_range_q) begin
          res_cnt_q  <= '0;
          res_mean_q <= '0;
          res_m2_q   <= '0;
          res_sat_q  <= 1'b0;
        end else begin
          // count at limit: stored values go out unchanged
          res_cnt_q  <= eff_cnt;
          res_mean_q <= eff_mean;
          res_m2_q   <= eff_m2;
          res_sat_q  <= 1'b1;
        end
      end
      S_SETUP: begin
        delta_neg_q <= delta_w[DELTA_W-1];
        dmag_q      <= dmag_w;
      end
      S_MEAN: nm_q   <= nm_w[MEAN_W-1:0];
      S_ERR:  emag_q <= emag_w;
      S_MUL:  prod_q <= dmag_q * emag_q;
      S_ACC: begin
        res_cnt_q  <= n_q;
        res_mean_q <= nm_q;
        res_m2_q   <= m2_new_w;
        res_sat_q  <= (n_q == CNT_MAX) || (m2_new_w == M2_MAX);
      end
      default: ;
    endcase
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.group_out  = out_grp_q;
  assign out_o.count      = out_cnt_q;
  assign out_o.mean       = out_mean_q;
  assign out_o.sq_dev_sum = out_m2_q;
  assign out_o.saturated  = out_sat_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_req.we && mem_req.re))
    else $error("store read and write in the same cycle");

  a_m2_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) |-> (m2_new_w >= m2_q))
    else $error("M2 decreased on update");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("item accepted while previous still in work");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("divider result outside divide step");

endmodule

// ----- sv/grmv_store.sv -----
// Per-group state memory: one write port, one read port, registered read data.
// Depends on grmv_pkg.
module grmv_store import grmv_pkg::*; (
  input  logic         clk_i,
  input  mem_req_t     req_i,
  output store_entry_t rdata_o
);

  store_entry_t mem_q [NUM_GROUPS];
  store_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/grmv_div.sv -----
// Iterative unsigned divider, |delta| / n, two quotient bits per cycle.
// Depends on grmv_pkg.
module grmv_div import grmv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  dmag_t                quo_q;   // dividend shifts out, quotient shifts in
  cnt_t                 rem_q;
  cnt_t                 dvs_q;

  dmag_t              quo_d;
  cnt_t               rem_d;
  logic [COUNT_WIDTH:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, quo_d[DMAG_W-1]};
      quo_d = {quo_d[DMAG_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[COUNT_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_STEPS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_last_step_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !req_i.start) |=> (done_q && !busy_q))
    else $error("divider did not finish after last step");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < dvs_q))
    else $error("divider remainder not below divisor");

endmodule

// ----- tb/grmv_checker.sv -----
`timescale 1ns / 100ps
// Checker for grouped_running_mean_variance: watches both channels, keeps its
// own per-group Welford state, and compares each result item with the oldest
// prediction. Depends on grmv_pkg and grmv_ifs.
module grmv_checker import grmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  grmv_in_if   in_mon,
  grmv_out_if  out_mon,
  output int   err_count_o,
  output int   outstanding_o
);

  typedef logic [63:0] u64_t;

  typedef struct packed {
    grp_t     grp;
    cnt_out_t cnt;
    mean_t    mean;
    m2_t      m2;
    logic     sat;
  } group_stats_t;

  group_stats_t expected_stats_q[$];
  group_stats_t head;
  int           err_count;

  cnt_t   grp_cnt  [NUM_GROUPS];
  longint grp_mean [NUM_GROUPS];  // Q8.24, always within 32 bits
  m2_t    grp_m2   [NUM_GROUPS];

  assign err_count_o = err_count;

  initial err_count = 0;

  task automatic flag_mismatch(string field, u64_t got, u64_t want);
    $display("[%0t] %s mismatch: got 0x%0h, expected 0x%0h", $time, field, got, want);
    err_count++;
  endtask

  // One Welford step on the shadow state; returns the stats the block must send.
  function automatic group_stats_t welford_update(grp_t g, sample_t s, logic rs);
    group_stats_t r;
    int           idx;
    int unsigned  n;
    longint       x;
    longint       delta;
    longint       nm;
    longint       err;
    u64_t         prod;
    u64_t         inc;
    r     = '0;
    r.grp = g;
    if (32'(g) >= NUM_GROUPS) return r;
    idx = int'(g);
    if (rs) begin
      grp_cnt[idx]  = '0;
      grp_mean[idx] = 0;
      grp_m2[idx]   = '0;
    end
    if (grp_cnt[idx] != CNT_MAX) begin
      n     = int'(grp_cnt[idx]) + 1;
      x     = longint'(s) * 65536;
      delta = x - grp_mean[idx];
      nm    = grp_mean[idx] + delta / longint'(n);  // truncates toward zero
      err   = x - nm;
      prod  = u64_t'(delta < 0 ? -delta : delta) * u64_t'(err < 0 ? -err : err);
      inc   = prod >> 32;
      if (inc >= u64_t'(M2_MAX) - u64_t'(grp_m2[idx])) grp_m2[idx] = M2_MAX;
      else grp_m2[idx] = grp_m2[idx] + m2_t'(inc);
      grp_cnt[idx]  = cnt_t'(n);
      grp_mean[idx] = nm;
    end
    r.cnt  = cnt_out_t'(grp_cnt[idx]);
    r.mean = mean_t'(grp_mean[idx]);
    r.m2   = grp_m2[idx];
    r.sat  = (grp_cnt[idx] == CNT_MAX) || (grp_m2[idx] == M2_MAX);
    return r;
  endfunction

  // Results are retired before the same-edge input is predicted: a result can
  // never belong to an item accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        grp_cnt[i]  = '0;
        grp_mean[i] = 0;
        grp_m2[i]   = '0;
      end
      expected_stats_q.delete();
      outstanding_o <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_stats_q.size() == 0) begin
          flag_mismatch("unexpected result, group", u64_t'(out_mon.group_out), '0);
        end else begin
          head = expected_stats_q.pop_front();
          if (out_mon.group_out !== head.grp)
            flag_mismatch("group_out", u64_t'(out_mon.group_out), u64_t'(head.grp));
          if (out_mon.count !== head.cnt)
            flag_mismatch("count", u64_t'(out_mon.count), u64_t'(head.cnt));
          if (out_mon.mean !== head.mean)
            flag_mismatch("mean", u64_t'(out_mon.mean), u64_t'(head.mean));
          if (out_mon.sq_dev_sum !== head.m2)
            flag_mismatch("sq_dev_sum", u64_t'(out_mon.sq_dev_sum), u64_t'(head.m2));
          if (out_mon.saturated !== head.sat)
            flag_mismatch("saturated", u64_t'(out_mon.saturated), u64_t'(head.sat));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_stats_q.push_back(welford_update(in_mon.group, in_mon.sample,
                                                  in_mon.restart));
      outstanding_o <= expected_stats_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the grouped_running_mean_variance testbench: clock, reset, stimulus,
// receiver back-pressure, watchdog and verdict. Depends on grmv_pkg, grmv_ifs,
// grmv_checker and the block itself.
module tb import grmv_pkg::*; ();

  // Longest stretch without any accepted item: covers the clearing pass after
  // reset and an update, plus random stalls on both sides.
  localparam int STALL_LIMIT = 2000;
  // Cycles allowed after the last result before the verdict.
  localparam int DRAIN_CYCLES = 48;

  logic clk_i;
  logic rst_ni;

  grmv_in_if  in_ch ();
  grmv_out_if out_ch ();

  int src_idle_pct;   // chance per cycle that the sender holds valid low
  int snk_idle_pct;   // chance per cycle that the receiver holds ready low
  int items_sent;
  int quiet_cycles;
  int mismatches;
  int in_flight;

  grouped_running_mean_variance dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  grmv_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_count_o   (mismatches),
    .outstanding_o (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random back-pressure, redrawn every cycle.
  always @(posedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= snk_idle_pct);
  end

  // Watchdog: any accept on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** grouped_running_mean_variance: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, idling first at random. Valid stays high on return so
  // back-to-back items never drop and raise it in the same step. While idle,
  // the payload carries junk that the block must ignore.
  task automatic send_item(grp_t g, sample_t s, logic rs);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid   <= 1'b0;
      in_ch.group   <= grp_t'($urandom);
      in_ch.sample  <= sample_t'($urandom);
      in_ch.restart <= 1'($urandom);
      @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.group   <= g;
    in_ch.sample  <= s;
    in_ch.restart <= rs;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // Sample source: full range, the two rails and zero/-1, or a value close to
  // a run's base so that means settle and M2 grows slowly.
  function automatic sample_t pick_sample(sample_t base);
    case ($urandom_range(0, 3))
      0: return sample_t'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      default: return base + sample_t'($urandom_range(0, 63)) - 16'sd32;
    endcase
  endfunction

  // Mostly a small pool of groups so that runs accumulate and get revisited.
  function automatic grp_t pick_group();
    if ($urandom_range(0, 3) == 0) return grp_t'($urandom);
    return grp_t'($urandom_range(0, 15));
  endfunction

  // Random part: mostly well-formed runs (restart, then more samples of the
  // same group), the rest single items on any group with random restart.
  task automatic run_random(int n_items);
    int      stop_at;
    int      len;
    grp_t    g;
    sample_t base;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      g    = pick_group();
      base = sample_t'($urandom);
      if ($urandom_range(0, 3) != 0) begin
        len = $urandom_range(1, 10);
        send_item(g, pick_sample(base), 1'b1);
        repeat (len) send_item(g, pick_sample(base), 1'b0);
      end else begin
        send_item(g, pick_sample(base), 1'($urandom_range(0, 7) == 0));
      end
    end
  endtask

  // Directed part: rails of the sample, first use of a group without
  // restart, restart in the middle of a run, truncation of negative deltas,
  // lowest and highest group.
  task automatic run_directed();
    send_item(8'd255, 16'shFFFF, 1'b0);   // untouched group, no restart
    send_item(8'd255, 16'sh0001, 1'b0);
    send_item(8'd0,   16'sh7FFF, 1'b1);
    send_item(8'd0,   16'sh8000, 1'b0);   // full-scale swing
    send_item(8'd0,   16'sh7FFF, 1'b0);
    send_item(8'd0,   16'sh8000, 1'b0);
    send_item(8'd0,   16'sh0000, 1'b1);   // restart mid-run
    send_item(8'd0,   16'sh0000, 1'b0);
    send_item(8'd1,   16'sh0000, 1'b1);
    send_item(8'd1,   16'shFFFF, 1'b0);   // small negative deltas
    send_item(8'd1,   16'shFFFF, 1'b0);
    send_item(8'd1,   16'shFFFE, 1'b0);
    send_item(8'd1,   16'sh0003, 1'b0);
    send_item(8'd128, 16'sh8000, 1'b1);
    send_item(8'd128, 16'sh8000, 1'b0);   // zero delta
    send_item(8'd128, 16'sh7FFF, 1'b0);
    send_item(8'd170, 16'sh5555, 1'b1);
    send_item(8'd85,  16'shAAAA, 1'b1);
    send_item(8'd255, 16'sh7FFF, 1'b1);
    send_item(8'd255, 16'sh8000, 1'b0);
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.group   = '0;
    in_ch.sample  = '0;
    in_ch.restart = 1'b0;
    out_ch.ready  = 1'b0;
    rst_ni        = 1'b0;
    items_sent    = 0;
    src_idle_pct  = 38;
    snk_idle_pct  = 55;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles less than the receiver.
    run_directed();
    run_random(130);

    // Roles swapped.
    src_idle_pct = 55;
    snk_idle_pct = 38;
    run_random(135);

    // Full rate both ways.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_random(135);
    run_random(10);
    in_ch.valid <= 1'b0;

    while (in_flight != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && in_flight == 0) begin
      $display("** grouped_running_mean_variance: PASSED **");
    end else begin
      $display("** grouped_running_mean_variance: FAILED **");
    end
    $finish;
  end

endmodule
